// ===== src/mef_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the MIDI event overwrite queue.
// Used by the cell, the cell chain and the top level; depends on nothing.
package mef_pkg;

   // Queue geometry.
   localparam int QUEUE_DEPTH = 16;
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam int INDEX_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int WORD_WIDTH  = 24;

   // Request operation codes.
   localparam logic OP_MESSAGE = 1'b0;
   localparam logic OP_POLL    = 1'b1;

   // Request payload: operation in the top bit, message word below it.
   typedef struct packed {
      logic                  operation;
      logic [WORD_WIDTH-1:0] message_word;
   } req_payload_type;

   // Result payload of one poll.
   typedef struct packed {
      logic       ready_res;
      logic [3:0] message_kind;
      logic [3:0] channel;
      logic [7:0] data_first;
      logic [7:0] data_second;
   } rsp_payload_type;

   // Control for one storage cell.
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

   // Control for the whole row of cells.
   typedef struct packed {
      logic                   shift;
      logic [QUEUE_DEPTH-1:0] load;
   } chain_ctrl_type;

endpackage

// ===== src/midi_event_overwrite_fifo.sv =====
`timescale 1ns / 1ps
// Top level of the MIDI event queue with overwrite on full.
// Depends on mef_pkg and instantiates mef_cell_chain.
//
// Usage:
//   The req channel carries a request that is either an arriving MIDI short
//   message or a poll. Messages are queued in a row of 16 cells, oldest in
//   cell zero; when the row is full the oldest message is discarded.
//   A poll produces one result on the rsp channel: the oldest message split
//   into kind, channel and data bytes with ready_res set, or all zeros when
//   the queue is empty or input is disabled. A message produces no result.
//   Throughput is one request per cycle while no poll waits: a request only
//   shifts or loads the cells and steps the fill counter. A poll's result is
//   presented in the cycle after it is accepted, from an output register.
//   When the receiver stalls, the held result stays put; messages are still
//   accepted, but a poll waits until the output register is free.
//   The csr port writes input_enabled; writing one empties the queue.
//   Reset is synchronous: input is disabled, the queue is empty and no
//   result is pending.
module midi_event_overwrite_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  mef_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output mef_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_write_enable,
   input  logic                     csr_write_data
);
   import mef_pkg::*;

   logic                   enabled_ff;
   logic                   enabled_in;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_payload_type        rsp_payload_ff;
   rsp_payload_type        rsp_payload_in;

   logic                   out_free;
   logic                   is_poll;
   logic                   req_accept;
   logic                   push;
   logic                   pop;
   logic                   full;
   chain_ctrl_type         chain_ctrl;
   logic [WORD_WIDTH-1:0]  head_word;

   // A poll needs the output register; messages never wait.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign is_poll    = (req_payload.operation == OP_POLL);
   assign req_stall  = req_valid && is_poll && !out_free;
   assign req_accept = req_valid && !req_stall;

   // Decode the accepted request into a push or a pop of the queue.
   assign full = (count_ff == COUNT_WIDTH'(QUEUE_DEPTH));
   assign push = req_accept && !is_poll && enabled_ff
                 && (req_payload.message_word[7:0] != 8'd0);
   assign pop  = req_accept && is_poll && enabled_ff && (count_ff != '0);

   // Cell control: shift on pop or on push into a full row; load at the tail.
   always_comb begin
      chain_ctrl.shift = pop || (push && full);
      chain_ctrl.load  = '0;
      if (push) begin
         if (full) begin
            chain_ctrl.load[QUEUE_DEPTH-1] = 1'b1;
         end else begin
            chain_ctrl.load[count_ff[INDEX_WIDTH-1:0]] = 1'b1;
         end
      end
   end

   mef_cell_chain u_chain (
      .clock     (clock),
      .ctrl      (chain_ctrl),
      .push_word (req_payload.message_word),
      .head_word (head_word)
   );

   // Enable register and fill counter.
   always_comb begin
      enabled_in = enabled_ff;
      count_in   = count_ff;
      if (csr_write_enable) begin
         enabled_in = csr_write_data;
         if (csr_write_data) begin
            count_in = '0;
         end
      end else if (push && !full) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end else if (pop) begin
         count_in = count_ff - COUNT_WIDTH'(1);
      end
   end

   // Output register for poll results.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (req_accept && is_poll) begin
         rsp_valid_in = 1'b1;
         if (pop) begin
            rsp_payload_in.ready_res    = 1'b1;
            rsp_payload_in.message_kind = head_word[7:4];
            rsp_payload_in.channel      = head_word[3:0];
            rsp_payload_in.data_first   = head_word[15:8];
            rsp_payload_in.data_second  = head_word[23:16];
         end else begin
            rsp_payload_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enabled_ff   <= enabled_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // The fill counter never passes the number of cells.
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(QUEUE_DEPTH))
      else $error("fill count above queue depth");

   // Every accepted poll leaves a result in the output register.
   a_poll_result : assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_poll) |=> rsp_valid_ff)
      else $error("poll accepted without a result");

   // A successful pop lowers the fill count by one.
   a_pop_count : assert property (@(posedge clock) disable iff (reset)
      (pop && !csr_write_enable) |=> (count_ff == $past(count_ff) - COUNT_WIDTH'(1)))
      else $error("pop did not decrement the fill count");

   // A push into a full queue keeps it full.
   a_full_push : assert property (@(posedge clock) disable iff (reset)
      (push && full && !csr_write_enable) |=> full)
      else $error("overwrite push changed the fill count");

   // A result with ready set only follows a poll of a non-empty queue.
   a_ready_source : assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_poll && !pop) |=> !rsp_payload_ff.ready_res)
      else $error("ready result from an empty or disabled queue");

endmodule

// ===== src/mef_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the queue row: holds one message word.
// Depends on mef_pkg for the word width and the cell control struct.
module mef_cell (
   input  logic                           clock,
   input  mef_pkg::cell_ctrl_type         ctrl,
   input  logic [mef_pkg::WORD_WIDTH-1:0] push_word,
   input  logic [mef_pkg::WORD_WIDTH-1:0] neighbor_word,
   output logic [mef_pkg::WORD_WIDTH-1:0] word
);
   import mef_pkg::*;

   logic [WORD_WIDTH-1:0] word_ff;
   logic [WORD_WIDTH-1:0] word_in;

   // A load takes the new word; a shift takes the word of the younger neighbor.
   always_comb begin
      word_in = word_ff;
      if (ctrl.load) begin
         word_in = push_word;
      end else if (ctrl.shift) begin
         word_in = neighbor_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

// ===== src/mef_cell_chain.sv =====
`timescale 1ns / 1ps
// Row of storage cells; cell zero holds the oldest message.
// Depends on mef_pkg and instantiates mef_cell once per queue entry.
module mef_cell_chain (
   input  logic                           clock,
   input  mef_pkg::chain_ctrl_type        ctrl,
   input  logic [mef_pkg::WORD_WIDTH-1:0] push_word,
   output logic [mef_pkg::WORD_WIDTH-1:0] head_word
);
   import mef_pkg::*;

   logic [WORD_WIDTH-1:0] cell_word [QUEUE_DEPTH];
   logic [WORD_WIDTH-1:0] next_word [QUEUE_DEPTH];

   genvar i;
   generate
      for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
         cell_ctrl_type cell_ctrl;

         // Each cell shifts toward the head; the last cell has no younger neighbor.
         if (i == QUEUE_DEPTH - 1) begin : g_last
            assign next_word[i] = '0;
         end else begin : g_inner
            assign next_word[i] = cell_word[i+1];
         end

         assign cell_ctrl.shift = ctrl.shift;
         assign cell_ctrl.load  = ctrl.load[i];

         mef_cell u_cell (
            .clock         (clock),
            .ctrl          (cell_ctrl),
            .push_word     (push_word),
            .neighbor_word (next_word[i]),
            .word          (cell_word[i])
         );
      end
   endgenerate

   assign head_word = cell_word[0];

endmodule
